// ===== design/dqe_pkg.sv =====
// Shared types and codes for the double-ended queue engine.
package dqe_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_WALK_FWD   = 3'd4,
        KIND_WALK_BWD   = 3'd5
    } kind_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

endpackage

// ===== design/dqe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/double_ended_queue_engine_core.sv =====
// Double-ended queue engine: bounded deque of signed words held in a ring RAM.
//
// A command beat is taken when start is high and busy is low; kind selects push front,
// push back, pop front, pop back, walk forward or walk backward, and value carries the
// word to push. Every result beat appears on value_res/status/last for exactly one cycle
// with strobe high; the receiver cannot stall, so it must take each beat as it comes.
// Timing: a push (or a push onto a full deque, or any pop/walk of an empty deque) is
// answered in the cycle after it is taken and does not raise busy, so one may follow
// every cycle. A pop of a non-empty deque reads the RAM, whose read is registered: its
// result passes the RAM read register, then the result register. A walk of N entries
// reads one entry a cycle from the RAM; results come on consecutive cycles and last
// marks the final one. A pop or walk that reads the RAM holds busy until its last read
// becomes a result. Kinds 6 and 7 are taken and ignored, giving no result. Pushed words
// keep their low DATA_WIDTH bits; words read back are sign-extended from DATA_WIDTH and
// cut to 32 bits. The RAM is not cleared at reset; only written entries are ever read.
module double_ended_queue_engine_core #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic signed [31:0] value,
    output logic               strobe,
    output logic signed [31:0] value_res,
    output logic [1:0]         status,
    output logic               last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // ring address: (a + b) mod DEPTH, both operands below DEPTH
    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // control and pointer state
    dqe_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic            back_reg, back_next;     // walk runs back to front
    logic            pend_reg, pend_next;     // RAM read data due this cycle
    logic            pend_last_reg, pend_last_next;

    // result register
    logic               strobe_reg, strobe_next;
    logic signed [31:0] value_res_reg, value_res_next;
    logic [1:0]         status_reg, status_next;
    logic               last_reg, last_next;

    // RAM port
    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] wr_data, rd_data;

    logic          accept;
    logic          full, empty;
    logic [AW-1:0] walk_off;
    logic          walk_end;

    dqe_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg != dqe_pkg::ST_IDLE) || pend_reg;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    // offset of the entry read this walk cycle, and whether it is the final one
    assign walk_off = back_reg ? AW'(count_reg - CW'(1) - CW'(idx_reg)) : idx_reg;
    assign walk_end = (CW'(idx_reg) == count_reg - CW'(1));

    // push data keeps the low bits of the 32-bit word, zero-extended if wider
    assign wr_data = DATA_WIDTH'($unsigned(value));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqe_pkg::ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            back_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            back_reg      <= back_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            strobe_reg    <= strobe_next;
        end
    end

    // result payload, qualified by strobe_reg
    always_ff @(posedge clk)
    begin
        value_res_reg <= value_res_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        back_next      = back_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        strobe_next    = 1'b0;
        value_res_next = value_res_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        // RAM read issued last cycle: turn it into a result beat
        if (pend_reg)
        begin
            strobe_next    = 1'b1;
            value_res_next = 32'($signed(rd_data));
            status_next    = dqe_pkg::STAT_OK;
            last_next      = pend_last_reg;
        end

        unique case (state_reg)
            dqe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        dqe_pkg::KIND_PUSH_FRONT,
                        dqe_pkg::KIND_PUSH_BACK:
                        begin
                            strobe_next    = 1'b1;
                            value_res_next = '0;
                            last_next      = 1'b1;
                            if (full)
                            begin
                                status_next = dqe_pkg::STAT_FULL;
                            end
                            else
                            begin
                                status_next = dqe_pkg::STAT_OK;
                                wr_en       = 1'b1;
                                count_next  = count_reg + CW'(1);
                                if (kind == dqe_pkg::KIND_PUSH_FRONT)
                                begin
                                    front_next = ring_add(front_reg, AW'(DEPTH - 1));
                                    wr_addr    = ring_add(front_reg, AW'(DEPTH - 1));
                                end
                                else
                                begin
                                    wr_addr = ring_add(front_reg, AW'(count_reg));
                                end
                            end
                        end
                        dqe_pkg::KIND_POP_FRONT,
                        dqe_pkg::KIND_POP_BACK:
                        begin
                            if (empty)
                            begin
                                strobe_next    = 1'b1;
                                value_res_next = '0;
                                status_next    = dqe_pkg::STAT_EMPTY;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                pend_next      = 1'b1;
                                pend_last_next = 1'b1;
                                count_next     = count_reg - CW'(1);
                                if (kind == dqe_pkg::KIND_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = ring_add(front_reg, AW'(1));
                                end
                                else
                                begin
                                    rd_addr = ring_add(front_reg,
                                                       AW'(count_reg - CW'(1)));
                                end
                            end
                        end
                        dqe_pkg::KIND_WALK_FWD,
                        dqe_pkg::KIND_WALK_BWD:
                        begin
                            if (empty)
                            begin
                                strobe_next    = 1'b1;
                                value_res_next = '0;
                                status_next    = dqe_pkg::STAT_EMPTY;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                state_next = dqe_pkg::ST_WALK;
                                idx_next   = '0;
                                back_next  = (kind == dqe_pkg::KIND_WALK_BWD);
                            end
                        end
                        default:
                        begin
                            // unused kinds: no effect, no result
                        end
                    endcase
                end
            end
            dqe_pkg::ST_WALK:
            begin
                // one RAM read per cycle; its data passes the RAM read register, then the result register
                rd_en          = 1'b1;
                rd_addr        = ring_add(front_reg, walk_off);
                pend_next      = 1'b1;
                pend_last_next = walk_end;
                if (walk_end)
                begin
                    state_next = dqe_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = dqe_pkg::ST_IDLE;
            end
        endcase
    end

    assign strobe    = strobe_reg;
    assign value_res = value_res_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ===== tb/sv/dqe_checker.sv =====
// Scoreboard for the deque engine: predicts result beats from command beats and compares them.
`timescale 1ns / 1ps

module dqe_checker #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         kind,
    input  logic signed [31:0] value,
    input  logic               strobe,
    input  logic signed [31:0] value_res,
    input  logic [1:0]         status,
    input  logic               last,
    output int                 pending,
    output int                 errors
);

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  stat;
        logic        fin;
    } beat_t;

    // shadow deque
    logic [63:0] ring [DEPTH];
    int          head;
    int          fill;

    beat_t       due_beats [$];
    int          err_cnt;
    int          shown;

    function automatic logic [63:0] word_mask();
        return (DATA_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << DATA_WIDTH) - 64'd1);
    endfunction

    function automatic logic [63:0] trim(input logic [31:0] v);
        return {32'd0, v} & word_mask();
    endfunction

    // sign-extend from DATA_WIDTH, cut to 32 bits
    function automatic logic [31:0] widen(input logic [63:0] raw);
        logic [63:0] w;
        w = raw & word_mask();
        if (DATA_WIDTH < 64 && w[DATA_WIDTH-1])
        begin
            w = w | ~word_mask();
        end
        return w[31:0];
    endfunction

    function automatic int slot(input int off);
        return (head + off) % DEPTH;
    endfunction

    task automatic note(input logic [31:0] w, input logic [1:0] st, input logic fin);
        beat_t b;
        b.word = w;
        b.stat = st;
        b.fin  = fin;
        due_beats.push_back(b);
    endtask

    task automatic apply_command(input logic [2:0] k, input logic [31:0] v);
        int off;
        case (k)
            dqe_pkg::KIND_PUSH_FRONT, dqe_pkg::KIND_PUSH_BACK:
            begin
                if (fill >= DEPTH)
                begin
                    note(32'd0, dqe_pkg::STAT_FULL, 1'b1);
                end
                else
                begin
                    if (k == dqe_pkg::KIND_PUSH_FRONT)
                    begin
                        head       = (head + DEPTH - 1) % DEPTH;
                        ring[head] = trim(v);
                    end
                    else
                    begin
                        ring[slot(fill)] = trim(v);
                    end
                    fill++;
                    note(32'd0, dqe_pkg::STAT_OK, 1'b1);
                end
            end
            dqe_pkg::KIND_POP_FRONT, dqe_pkg::KIND_POP_BACK:
            begin
                if (fill == 0)
                begin
                    note(32'd0, dqe_pkg::STAT_EMPTY, 1'b1);
                end
                else
                begin
                    if (k == dqe_pkg::KIND_POP_FRONT)
                    begin
                        note(widen(ring[head]), dqe_pkg::STAT_OK, 1'b1);
                        head = slot(1);
                    end
                    else
                    begin
                        note(widen(ring[slot(fill - 1)]), dqe_pkg::STAT_OK, 1'b1);
                    end
                    fill--;
                end
            end
            dqe_pkg::KIND_WALK_FWD, dqe_pkg::KIND_WALK_BWD:
            begin
                if (fill == 0)
                begin
                    note(32'd0, dqe_pkg::STAT_EMPTY, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        off = (k == dqe_pkg::KIND_WALK_FWD) ? i : (fill - 1 - i);
                        note(widen(ring[slot(off)]), dqe_pkg::STAT_OK, (i + 1 == fill));
                    end
                end
            end
            default: ; // spare kinds: no effect, no beat
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ring[i] = '0;
            end
            head = 0;
            fill = 0;
            due_beats.delete();
            err_cnt = 0;
            shown   = 0;
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            // result beats belong to earlier commands, so compare before predicting
            if (strobe)
            begin
                if (due_beats.size() == 0)
                begin
                    err_cnt++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("[%0t] unexpected beat: value_res=%h status=%0d last=%0b",
                                 $realtime, value_res, status, last);
                    end
                end
                else
                begin
                    e = due_beats.pop_front();
                    if (value_res !== e.word || status !== e.stat || last !== e.fin)
                    begin
                        err_cnt++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display({"[%0t] beat differs: value_res exp %h got %h, ",
                                      "status exp %0d got %0d, last exp %0b got %0b"},
                                     $realtime, e.word, value_res, e.stat, status,
                                     e.fin, last);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                apply_command(kind, value);
            end
            pending <= due_beats.size();
            errors  <= err_cnt;
        end
    end

endmodule

// ===== tb/sv/double_ended_queue_engine_core_tb.sv =====
// Testbench top for the deque engine: drives command beats and reports the verdict.
`timescale 1ns / 1ps

module double_ended_queue_engine_core_tb;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;

    // spare kind codes, taken by the block and ignored
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // stimulus mix per phase
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_BLEND = 2;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         kind  = '0;
    logic signed [31:0] value = '0;
    logic               strobe;
    logic signed [31:0] value_res;
    logic [1:0]         status;
    logic               last;

    int pending;
    int errors;
    int calm_left = 0;

    double_ended_queue_engine_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .strobe    (strobe),
        .value_res (value_res),
        .status    (status),
        .last      (last)
    );

    dqe_checker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .strobe    (strobe),
        .value_res (value_res),
        .status    (status),
        .last      (last),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hand one command beat to the block. A random idle gap goes first; with no gap,
    // start stays high from the previous beat so it is never dropped and raised in
    // one step. Returns at the edge that takes the beat.
    task automatic send_cmd(input logic [2:0] k, input logic [31:0] v);
        int gap;
        if (calm_left > 0)
        begin
            gap = 0;
            calm_left--;
        end
        else
        begin
            gap = $urandom_range(0, 6);
            // now and then a run of back-to-back beats
            if ($urandom_range(0, 19) == 0)
            begin
                calm_left = $urandom_range(5, 20);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            kind  <= 3'($urandom_range(0, 7));   // idle bus carries junk
            value <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind  <= k;
        value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold off the sender until every predicted beat has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Words weighted towards the corners of the signed range.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Kind draw for a phase. Fill phases push hard so the ring fills and pushes
    // get dropped; drain phases empty it and hit the empty cases.
    function automatic logic [2:0] pick_kind(input int mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                if (r < 42)      return dqe_pkg::KIND_PUSH_FRONT;
                else if (r < 84) return dqe_pkg::KIND_PUSH_BACK;
                else if (r < 89) return dqe_pkg::KIND_POP_FRONT;
                else if (r < 93) return dqe_pkg::KIND_POP_BACK;
                else if (r < 96) return dqe_pkg::KIND_WALK_FWD;
                else if (r < 99) return dqe_pkg::KIND_WALK_BWD;
            end
            MIX_DRAIN:
            begin
                if (r < 6)       return dqe_pkg::KIND_PUSH_FRONT;
                else if (r < 12) return dqe_pkg::KIND_PUSH_BACK;
                else if (r < 50) return dqe_pkg::KIND_POP_FRONT;
                else if (r < 88) return dqe_pkg::KIND_POP_BACK;
                else if (r < 93) return dqe_pkg::KIND_WALK_FWD;
                else if (r < 98) return dqe_pkg::KIND_WALK_BWD;
            end
            default:
            begin
                if (r < 20)      return dqe_pkg::KIND_PUSH_FRONT;
                else if (r < 40) return dqe_pkg::KIND_PUSH_BACK;
                else if (r < 60) return dqe_pkg::KIND_POP_FRONT;
                else if (r < 80) return dqe_pkg::KIND_POP_BACK;
                else if (r < 89) return dqe_pkg::KIND_WALK_FWD;
                else if (r < 98) return dqe_pkg::KIND_WALK_BWD;
            end
        endcase
        return ($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
    endfunction

    // One random phase; spare kinds are sent but not counted towards its length.
    task automatic run_phase(input int mix, input int beats);
        int done;
        logic [2:0] k;
        done = 0;
        while (done < beats)
        begin
            k = pick_kind(mix);
            send_cmd(k, pick_word());
            if (k != KIND_SPARE_LO && k != KIND_SPARE_HI)
            begin
                done++;
            end
            if ($urandom_range(0, 39) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        int guard;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases first, then corner words, both walks, spare kinds,
        // and pops in both directions down to empty again.
        send_cmd(dqe_pkg::KIND_WALK_FWD,   32'h1234_5678);
        send_cmd(dqe_pkg::KIND_WALK_BWD,   32'h8765_4321);
        send_cmd(dqe_pkg::KIND_POP_FRONT,  32'hFFFF_FFFF);
        send_cmd(dqe_pkg::KIND_POP_BACK,   32'h0000_0000);
        send_cmd(dqe_pkg::KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        send_cmd(dqe_pkg::KIND_PUSH_BACK,  32'h8000_0000);
        send_cmd(dqe_pkg::KIND_PUSH_FRONT, 32'h0000_0000);
        send_cmd(dqe_pkg::KIND_PUSH_BACK,  32'hFFFF_FFFF);
        send_cmd(dqe_pkg::KIND_PUSH_BACK,  32'h5555_5555);
        send_cmd(dqe_pkg::KIND_PUSH_FRONT, 32'hAAAA_AAAA);
        send_cmd(dqe_pkg::KIND_WALK_FWD,   32'h0000_0000);
        send_cmd(dqe_pkg::KIND_WALK_BWD,   32'hFFFF_FFFF);
        send_cmd(KIND_SPARE_LO,            32'hDEAD_BEEF);
        send_cmd(KIND_SPARE_HI,            32'h0BAD_F00D);
        send_cmd(dqe_pkg::KIND_POP_FRONT,  32'h0000_0000);
        send_cmd(dqe_pkg::KIND_POP_BACK,   32'h0000_0000);
        send_cmd(dqe_pkg::KIND_POP_FRONT,  32'h0000_0000);
        send_cmd(dqe_pkg::KIND_POP_BACK,   32'h0000_0000);
        send_cmd(dqe_pkg::KIND_POP_BACK,   32'h0000_0000);
        send_cmd(dqe_pkg::KIND_POP_FRONT,  32'h0000_0000);
        send_cmd(dqe_pkg::KIND_POP_FRONT,  32'h0000_0000);
        send_cmd(dqe_pkg::KIND_WALK_FWD,   32'h0000_0000);

        // sender holds off until the block has answered everything
        wait_drained();

        // Random: a fill phase, a drain phase, a blend, then fill again.
        run_phase(MIX_FILL,  40);
        run_phase(MIX_DRAIN, 40);
        run_phase(MIX_BLEND, 22);
        run_phase(MIX_FILL,  36);

        start <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        // quiet tail: any stray beat here shows up as unexpected
        repeat (8) @(posedge clk);
        @(negedge clk);

        if (errors == 0 && pending == 0)
        begin
            $display("double_ended_queue_engine_core: match");
        end
        else
        begin
            $display("double_ended_queue_engine_core: mismatch");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("double_ended_queue_engine_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dqe_pkg.sv
design/dqe_ram.sv
design/double_ended_queue_engine_core.sv
tb/sv/dqe_checker.sv
tb/sv/double_ended_queue_engine_core_tb.sv
